// ===== sv/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// shared types, constants and tables of the gregorian date arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

   localparam int SERIAL_W = 26;
   localparam int DAYNUM_W = 25;
   localparam int DIFF_W   = 22;
   localparam int OFF_W    = 20;

   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_DIFF = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  first_day;
      logic [3:0]  first_month;
      logic [13:0] first_year;
      logic [4:0]  second_day;
      logic [3:0]  second_month;
      logic [13:0] second_year;
      logic [19:0] day_offset;
   } req_type;

   typedef struct packed {
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [13:0] out_year;
      logic [21:0] day_difference;
      logic        range_error;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [4:0]        day;
      logic [3:0]        month;
      logic [13:0]       year;
      logic              err;
      logic [DIFF_W-1:0] diff;
   } ctx_type;

   // days before the first of month m in a common year
   function automatic logic [8:0] cum_days(input logic [3:0] m);
      logic [8:0] v;
      case (m)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gregorian_date_arithmetic_top.sv =====
// throughput: one word per cycle, the pipeline advances whenever the
//   response register is empty or taken
// the pipeline stalls as a whole while a response waits on rsp_stall
// reset clears the valid bits of every stage, payload is not reset
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top
// adds or subtracts days from a date, or gives the day count between two dates
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_arithmetic_top
   import gda_pkg::*;
#(
   parameter int MAX_YEAR    = 9999,
   parameter int OFFSET_BITS = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   function automatic longint days_before(input longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   localparam logic [SERIAL_W-1:0] LIMIT =
      SERIAL_W'(days_before(longint'(MAX_YEAR) + 1));
   localparam logic [OFF_W-1:0] OFF_MASK =
      OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [SERIAL_W-1:0] DIFF_MAX = SERIAL_W'((64'd1 << DIFF_W) - 64'd1);

   logic en;

   logic [1:0]       v_ff;
   ctx_type          ctx0_in, ctx0_ff, ctx1_ff;
   logic [OFF_W-1:0] off0_ff, off1_ff;

   logic [SERIAL_W-1:0] serial_a, serial_b;
   logic [SERIAL_W-1:0] off_ext, s_in, absd;
   logic                bad;
   ctx_type             ctx2_in, ctx2_ff;
   logic                v2_ff;
   logic [DAYNUM_W-1:0] num_in, num_ff;

   logic        civ_valid;
   ctx_type     civ_ctx;
   logic [15:0] civ_year;
   logic [3:0]  civ_month;
   logic [4:0]  civ_day;

   logic    rsp_valid_ff;
   rsp_type rsp_data_in, rsp_data_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      ctx0_in       = '0;
      ctx0_in.mode  = req_data.mode;
      ctx0_in.day   = req_data.first_day;
      ctx0_in.month = req_data.first_month;
      ctx0_in.year  = req_data.first_year;
   end

   gda_serial u_first (
      .clock  (clock),
      .en     (en),
      .day    (req_data.first_day),
      .month  (req_data.first_month),
      .year   (req_data.first_year),
      .serial (serial_a)
   );

   gda_serial u_second (
      .clock  (clock),
      .en     (en),
      .day    (req_data.second_day),
      .month  (req_data.second_month),
      .year   (req_data.second_year),
      .serial (serial_b)
   );

   always_comb begin
      off_ext = SERIAL_W'(off1_ff & OFF_MASK);
      s_in    = (ctx1_ff.mode == MODE_SUB) ? serial_a - off_ext : serial_a + off_ext;
      bad     = ((ctx1_ff.mode == MODE_SUB) && serial_a <= off_ext) || s_in > LIMIT
              || s_in == '0;
      absd    = (serial_a > serial_b) ? serial_a - serial_b : serial_b - serial_a;
      num_in  = DAYNUM_W'(s_in - SERIAL_W'(1));
      ctx2_in = ctx1_ff;
      case (ctx1_ff.mode)
         MODE_ADD, MODE_SUB: begin
            ctx2_in.err = bad;
         end
         MODE_DIFF: begin
            ctx2_in.diff = (absd > DIFF_MAX) ? '1 : absd[DIFF_W-1:0];
         end
         default: begin
            ctx2_in.err = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[0], req_valid};
         v2_ff <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx0_ff <= ctx0_in;
         ctx1_ff <= ctx0_ff;
         off0_ff <= req_data.day_offset;
         off1_ff <= off0_ff;
         ctx2_ff <= ctx2_in;
         num_ff  <= num_in;
      end
   end

   gda_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_ctx    (ctx2_ff),
      .in_num    (num_ff),
      .out_valid (civ_valid),
      .out_ctx   (civ_ctx),
      .out_year  (civ_year),
      .out_month (civ_month),
      .out_day   (civ_day)
   );

   always_comb begin
      rsp_data_in = '0;
      case (civ_ctx.mode)
         MODE_ADD, MODE_SUB: begin
            rsp_data_in.range_error = civ_ctx.err;
            if (civ_ctx.err) begin
               rsp_data_in.out_day   = civ_ctx.day;
               rsp_data_in.out_month = civ_ctx.month;
               rsp_data_in.out_year  = civ_ctx.year;
            end else begin
               rsp_data_in.out_day   = civ_day;
               rsp_data_in.out_month = civ_month;
               rsp_data_in.out_year  = civ_year[13:0];
            end
         end
         MODE_DIFF: begin
            rsp_data_in.day_difference = civ_ctx.diff;
         end
         default: begin
            rsp_data_in.range_error = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= civ_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_err_no_diff : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.range_error |-> rsp_data_ff.day_difference == '0)
      else $error("range error with a day difference");

   a_date_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.range_error && rsp_data_ff.out_year != '0
      |-> rsp_data_ff.out_month >= 4'd1 && rsp_data_ff.out_month <= 4'd12
          && rsp_data_ff.out_day >= 5'd1)
      else $error("result date out of calendar");

   a_year_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.range_error
      |-> 32'(rsp_data_ff.out_year) <= 32'(MAX_YEAR))
      else $error("result year above limit");

endmodule

`default_nettype wire

// ===== sv/gda_serial.sv =====
// ----------------------------------------------------------------------------
// gda_serial
// two-stage conversion of a date to its serial day number, 1/1/1 is day 1
// ----------------------------------------------------------------------------
`default_nettype none

module gda_serial
   import gda_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          day,
   input  logic [3:0]          month,
   input  logic [13:0]         year,
   output logic [SERIAL_W-1:0] serial
);

   localparam int K100 = 21;
   localparam int K400 = 23;
   localparam logic [14:0] M100 = 15'(((64'd1 << K100) + 64'd99) / 64'd100);
   localparam logic [14:0] M400 = 15'(((64'd1 << K400) + 64'd399) / 64'd400);

   logic [13:0] yn, p;
   logic [3:0]  mn;
   logic [28:0] pm100, ym100, pm400, ym400;
   logic [7:0]  p100, y100;
   logic [5:0]  p400, y400;
   logic        leap;

   logic [22:0] base_in, base_ff;
   logic [11:0] q4_ff;
   logic [7:0]  q100_ff;
   logic [5:0]  q400_ff;
   logic [8:0]  cum_in, cum_ff;
   logic [4:0]  day_ff;
   logic [SERIAL_W-1:0] serial_in, serial_ff;

   always_comb begin
      yn = (year == 14'd0) ? 14'd1 : year;
      p  = yn - 14'd1;
      if (month == 4'd0) begin
         mn = 4'd1;
      end else if (month > 4'd12) begin
         mn = 4'd12;
      end else begin
         mn = month;
      end
      pm100 = 29'(p) * 29'(M100);
      ym100 = 29'(yn) * 29'(M100);
      pm400 = 29'(p) * 29'(M400);
      ym400 = 29'(yn) * 29'(M400);
      p100  = pm100[K100 +: 8];
      y100  = ym100[K100 +: 8];
      p400  = pm400[K400 +: 6];
      y400  = ym400[K400 +: 6];
      // year divisible by n exactly when its quotient steps past that of year-1
      leap    = (p[1:0] == 2'd3 && y100 == p100) || (y400 != p400);
      base_in = 23'(p) * 23'(365);
      cum_in  = cum_days(mn) + 9'((leap && mn > 4'd2) ? 1 : 0);
      serial_in = SERIAL_W'(base_ff) + SERIAL_W'(q4_ff) - SERIAL_W'(q100_ff)
                + SERIAL_W'(q400_ff) + SERIAL_W'(cum_ff) + SERIAL_W'(day_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff   <= base_in;
         q4_ff     <= p[13:2];
         q100_ff   <= p100;
         q400_ff   <= p400;
         cum_ff    <= cum_in;
         day_ff    <= day;
         serial_ff <= serial_in;
      end
   end

   assign serial = serial_ff;

endmodule

`default_nettype wire

// ===== sv/gda_civil.sv =====
// ----------------------------------------------------------------------------
// gda_civil
// nine-stage conversion of a zero-based day number back to a date
// ----------------------------------------------------------------------------
`default_nettype none

module gda_civil
   import gda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ctx_type             in_ctx,
   input  logic [DAYNUM_W-1:0] in_num,
   output logic                out_valid,
   output ctx_type             out_ctx,
   output logic [15:0]         out_year,
   output logic [3:0]          out_month,
   output logic [4:0]          out_day
);

   localparam int NSTG = 9;
   localparam int K1 = DAYNUM_W + 18;
   localparam int K3 = 34;
   localparam int K5 = 27;
   localparam logic [25:0] M1 = 26'(((64'd1 << K1) + 64'd146096) / 64'd146097);
   localparam logic [18:0] M3 = 19'(((64'd1 << K3) + 64'd36523) / 64'd36524);
   localparam logic [16:0] M5 = 17'(((64'd1 << K5) + 64'd1460) / 64'd1461);

   function automatic logic [8:0] cum_leap(input logic [3:0] m, input logic lp);
      logic [8:0] v;
      v = cum_days(m) + 9'((lp && m > 4'd2) ? 1 : 0);
      return v;
   endfunction

   logic [NSTG-1:0] v_ff;
   ctx_type         ctx_ff [NSTG];

   logic [DAYNUM_W-1:0] num_ff;
   logic [50:0] p1;
   logic [7:0]  q400_in;
   logic [7:0]  q400_ff [7];
   logic [17:0] r_in, r_ff, rd_ff;
   logic [36:0] p3;
   logic [2:0]  q100_raw;
   logic [1:0]  q100_in;
   logic [1:0]  q100_ff [5];
   logic [17:0] r2_full;
   logic [15:0] r2_in, r2_ff, r2d_ff;
   logic [32:0] p5;
   logic [4:0]  q4_in;
   logic [4:0]  q4_ff [3];
   logic [15:0] r3_full;
   logic [10:0] r3_in, r3_ff;
   logic [1:0]  q1_in, q1_ff;
   logic [8:0]  r4_in, r4_ff, r5_ff;
   logic [16:0] year_full;
   logic [15:0] year_ff, year2_ff;
   logic        leap_in, leap_ff;
   logic [3:0]  month_in, month_ff;
   logic [8:0]  day_full;
   logic [4:0]  day_ff;

   always_comb begin
      // stage 1: 400-year cycles
      p1      = 51'(in_num) * 51'(M1);
      q400_in = p1[K1 +: 8];
      // stage 2: remainder within the cycle
      r_in = 18'(num_ff - DAYNUM_W'(25'(q400_ff[0]) * 25'(146097)));
      // stage 3: centuries, the last one takes the extra day
      p3       = 37'(r_ff) * 37'(M3);
      q100_raw = p3[K3 +: 3];
      q100_in  = (q100_raw > 3'd3) ? 2'd3 : q100_raw[1:0];
      // stage 4
      r2_full = rd_ff - 18'(18'(q100_ff[0]) * 18'(36524));
      r2_in   = r2_full[15:0];
      // stage 5: 4-year groups
      p5    = 33'(r2_ff) * 33'(M5);
      q4_in = p5[K5 +: 5];
      // stage 6
      r3_full = r2d_ff - 16'(16'(q4_ff[0]) * 16'(1461));
      r3_in   = r3_full[10:0];
      // stage 7: single years
      if (r3_ff >= 11'd1095) begin
         q1_in = 2'd3;
      end else if (r3_ff >= 11'd730) begin
         q1_in = 2'd2;
      end else if (r3_ff >= 11'd365) begin
         q1_in = 2'd1;
      end else begin
         q1_in = 2'd0;
      end
      r4_in = 9'(r3_ff - 11'(11'(q1_in) * 11'd365));
      // stage 8: year and month
      year_full = 17'(q400_ff[6]) * 17'd400 + 17'(q100_ff[4]) * 17'd100
                + 17'(q4_ff[2]) * 17'd4 + 17'(q1_ff) + 17'd1;
      leap_in  = (q1_ff == 2'd3) && (q4_ff[2] != 5'd24 || q100_ff[4] == 2'd3);
      month_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         month_in = month_in + 4'((r4_ff >= cum_leap(4'(k), leap_in)) ? 1 : 0);
      end
      // stage 9: day of month
      day_full = r5_ff - cum_leap(month_ff, leap_ff) + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= in_ctx;
         for (int i = 1; i < NSTG; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
         num_ff     <= in_num;
         q400_ff[0] <= q400_in;
         for (int i = 1; i < 7; i++) begin
            q400_ff[i] <= q400_ff[i-1];
         end
         r_ff       <= r_in;
         rd_ff      <= r_ff;
         q100_ff[0] <= q100_in;
         for (int i = 1; i < 5; i++) begin
            q100_ff[i] <= q100_ff[i-1];
         end
         r2_ff      <= r2_in;
         r2d_ff     <= r2_ff;
         q4_ff[0]   <= q4_in;
         q4_ff[1]   <= q4_ff[0];
         q4_ff[2]   <= q4_ff[1];
         r3_ff      <= r3_in;
         q1_ff      <= q1_in;
         r4_ff      <= r4_in;
         year_ff    <= year_full[15:0];
         leap_ff    <= leap_in;
         month_ff   <= month_in;
         r5_ff      <= r4_ff;
         year2_ff   <= year_ff;
         day_ff     <= day_full[4:0];
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_ctx   = ctx_ff[NSTG-1];
   assign out_year  = year2_ff;
   assign out_day   = day_ff;

   logic [3:0] month2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         month2_ff <= month_ff;
      end
   end
   assign out_month = month2_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives date add, subtract and difference words into the date unit with
// random gaps and stalls, predicts each response from a serial day count
// and compares every field in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import gda_pkg::*;

   localparam int MAX_YR   = 9999;
   localparam int OFF_BITS = 20;
   localparam int WATCHDOG = 20000;
   localparam int REQ_W    = $bits(req_type);
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_dates[$];
   int      mismatches;
   int      idle_cycles;

   gregorian_date_arithmetic_top #(
      .MAX_YEAR(MAX_YR),
      .OFFSET_BITS(OFF_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit leap_year(longint y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic longint month_days(longint m, longint y);
      longint lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && leap_year(y))
         return 29;
      return lens[m > 12 ? 12 : m];
   endfunction

   function automatic longint days_to_year(longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic longint day_count(longint d, longint m, longint y);
      longint s;
      if (y == 0) y = 1;
      if (m == 0) m = 1;
      if (m > 12) m = 12;
      s = days_to_year(y);
      for (longint i = 1; i < m; i++)
         s += month_days(i, y);
      return s + d;
   endfunction

   function automatic rsp_type predict_date(req_type r);
      rsp_type o;
      longint  s, a, b, n, q400, q100, q4, q1, rem, y, mo, lim, off;
      bit      bad;
      o = '0;
      off = longint'(r.day_offset) & ((longint'(1) << OFF_BITS) - 1);
      if (r.mode == MODE_ADD || r.mode == MODE_SUB) begin
         s = day_count(longint'(r.first_day), longint'(r.first_month),
                       longint'(r.first_year));
         lim = days_to_year(MAX_YR + 1);
         bad = 1'b0;
         if (r.mode == MODE_ADD) s += off;
         else if (s <= off) bad = 1'b1;
         else s -= off;
         if (!bad && (s < 1 || s > lim)) bad = 1'b1;
         if (bad) begin
            o.range_error = 1'b1;
            o.out_day = r.first_day;
            o.out_month = r.first_month;
            o.out_year = r.first_year;
         end else begin
            n = s - 1;
            q400 = n / 146097;
            rem = n % 146097;
            q100 = rem / 36524;
            if (q100 > 3) q100 = 3;
            rem -= q100 * 36524;
            q4 = rem / 1461;
            rem %= 1461;
            q1 = rem / 365;
            if (q1 > 3) q1 = 3;
            rem -= q1 * 365;
            y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
            mo = 1;
            while (rem >= month_days(mo, y) && mo < 12) begin
               rem -= month_days(mo, y);
               mo++;
            end
            o.out_day = 5'(rem + 1);
            o.out_month = 4'(mo);
            o.out_year = 14'(y);
         end
      end else if (r.mode == MODE_DIFF) begin
         a = day_count(longint'(r.first_day), longint'(r.first_month),
                       longint'(r.first_year));
         b = day_count(longint'(r.second_day), longint'(r.second_month),
                       longint'(r.second_year));
         n = a > b ? a - b : b - a;
         if (n > 4194303) n = 4194303;
         o.day_difference = 22'(n);
      end
      return o;
   endfunction

   // sends one word after a random gap, valid stays high until the next gap
   task automatic send_word(req_type r);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_dates.push_back(predict_date(r));
   endtask

   // drops valid after the last word of a burst
   task automatic release_bus();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type rand_word(logic [1:0] m);
      req_type r;
      r = '0;
      r.mode = m;
      r.first_day = 5'($urandom_range(1, 28));
      r.first_month = 4'($urandom_range(1, 12));
      r.first_year = 14'($urandom_range(1, 9999));
      r.second_day = 5'($urandom_range(1, 28));
      r.second_month = 4'($urandom_range(1, 12));
      r.second_year = 14'($urandom_range(1, 9999));
      case ($urandom_range(0, 3))
         0: r.day_offset = 20'($urandom_range(0, 400));
         1: r.day_offset = 20'($urandom_range(0, 40000));
         default: r.day_offset = 20'($urandom);
      endcase
      return r;
   endfunction

   task automatic send(logic [1:0] m, int d1, int m1, int y1, int d2, int m2, int y2,
                       int off);
      req_type r;
      r = '0;
      r.mode = m;
      r.first_day = 5'(d1); r.first_month = 4'(m1); r.first_year = 14'(y1);
      r.second_day = 5'(d2); r.second_month = 4'(m2); r.second_year = 14'(y2);
      r.day_offset = 20'(off);
      send_word(r);
   endtask

   task automatic test_directed();
      send(MODE_ADD, 1, 1, 1, 1, 1, 1, 0);
      send(MODE_ADD, 28, 2, 2000, 0, 0, 0, 1);
      send(MODE_ADD, 28, 2, 1900, 0, 0, 0, 1);
      send(MODE_ADD, 31, 12, 9999, 0, 0, 0, 1);
      send(MODE_ADD, 1, 1, 1, 0, 0, 0, 20'hFFFFF);
      send(MODE_SUB, 1, 1, 1, 0, 0, 0, 1);
      send(MODE_SUB, 1, 3, 2004, 0, 0, 0, 1);
      send(MODE_SUB, 31, 12, 9999, 0, 0, 0, 20'hFFFFF);
      send(MODE_SUB, 0, 3, 2001, 0, 0, 0, 0);
      send(MODE_ADD, 31, 4, 2001, 0, 0, 0, 0);
      send(MODE_ADD, 31, 15, 16383, 0, 0, 0, 0);
      send(MODE_SUB, 31, 0, 0, 0, 0, 0, 0);
      send(MODE_ADD, 0, 1, 1, 0, 0, 0, 0);
      send(MODE_ADD, 0, 0, 0, 0, 0, 0, 1);
      send(MODE_DIFF, 1, 1, 1, 31, 12, 9999, 0);
      send(MODE_DIFF, 31, 15, 16383, 0, 0, 0, 0);
      send(MODE_DIFF, 15, 6, 2020, 15, 6, 2020, 0);
      send(MODE_UNUSED, 31, 15, 16383, 31, 15, 16383, 20'hFFFFF);
      send(MODE_ADD, 31, 12, 9998, 0, 0, 0, 365);
   endtask

   task automatic test_random(int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r = rand_word(2'($urandom_range(0, 2)));
         if ($urandom_range(0, 9) == 0) r = REQ_W'({$urandom, $urandom, $urandom});
         else if ($urandom_range(0, 9) == 0) r.day_offset = 20'($urandom);
         if ($urandom_range(0, 30) == 0) r.mode = MODE_UNUSED;
         send_word(r);
      end
   endtask

   // pauses the sender until the pipe drains, then sends 20 more random words
   task automatic test_drain();
      release_bus();
      while (expected_dates.size() != 0) @(posedge clock);
      test_random(20);
   endtask

   // response checker with random stall
   initial begin
      int stall_left;
      rsp_type want;
      rsp_stall <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %p", rsp_data);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
            stall_left = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("** gregorian_date_arithmetic_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_drain();
      test_random(280);
      release_bus();
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("** gregorian_date_arithmetic_top: PASSED **");
      else
         $display("** gregorian_date_arithmetic_top: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== gregorian_date_arithmetic_top.f =====
sv/gda_pkg.sv
sv/gda_serial.sv
sv/gda_civil.sv
sv/gregorian_date_arithmetic_top.sv
test/tb_top.sv
